### rtl/core/tgarle_pkg.sv
// Shared types and constants of the TGA pixel data decoder.
// Used by tgarle_step and tga_rle_pixel_decoder; depends on nothing.

package tgarle_pkg;

   localparam int BYTE_W     = 8;
   localparam int BPP_W      = 3;
   localparam int TOTAL_W    = 32;
   localparam int COUNT_W    = 8;
   localparam int INDEX_W    = 2;
   localparam int LANES      = 4;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RLE_MODE        = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PIXEL_TOTAL     = 2'd2;

   localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd3;
   localparam logic [BPP_W-1:0]   BPP_MIN     = 3'd1;
   localparam logic [BPP_W-1:0]   BPP_MAX     = 3'd4;
   localparam logic [BPP_W-1:0]   BPP_SWAP    = 3'd3;
   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 32'd1;

   localparam int RUN_BIT = 7;
   localparam logic [BYTE_W-1:0] COUNT_MASK = 8'h7f;

   typedef struct packed {
      logic [BPP_W-1:0]   bytes_per_pixel;
      logic               rle_mode;
      logic [TOTAL_W-1:0] pixel_total;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  pix_byte0;
      logic [BYTE_W-1:0]  pix_byte1;
      logic [BYTE_W-1:0]  pix_byte2;
      logic [BYTE_W-1:0]  pix_byte3;
      logic [COUNT_W-1:0] repeat_count;
      logic               clipped;
      logic               last;
   } result_type;

endpackage

### rtl/core/tgarle_step.sv
// Decode state of the TGA pixel data decoder: packet header tracking, pixel
// assembly and image progress. Produces at most one result per item.
// Depends on tgarle_pkg.

module tgarle_step (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [tgarle_pkg::BYTE_W-1:0]  in_byte,
   input  tgarle_pkg::cfg_type            cfg,
   output logic                           res_valid,
   output tgarle_pkg::result_type         res
);

   logic                               expect_header_ff, expect_header_in;
   logic                               packet_is_run_ff, packet_is_run_in;
   logic [tgarle_pkg::COUNT_W-1:0]     packet_left_ff, packet_left_in;
   logic [tgarle_pkg::INDEX_W-1:0]     byte_index_ff, byte_index_in;
   logic [tgarle_pkg::BYTE_W-1:0]      pixel_buffer_ff [tgarle_pkg::LANES];
   logic [tgarle_pkg::BYTE_W-1:0]      pixel_buffer_in [tgarle_pkg::LANES];
   logic [tgarle_pkg::TOTAL_W-1:0]     pixels_done_ff, pixels_done_in;

   logic [tgarle_pkg::BPP_W-1:0]       bpp;
   logic [tgarle_pkg::TOTAL_W-1:0]     total;
   logic [tgarle_pkg::TOTAL_W-1:0]     remaining;
   logic [tgarle_pkg::TOTAL_W-1:0]     want_wide;
   logic [tgarle_pkg::COUNT_W-1:0]     want;
   logic [tgarle_pkg::COUNT_W-1:0]     count;
   logic [tgarle_pkg::BYTE_W-1:0]      px [tgarle_pkg::LANES];
   logic                               header;
   logic                               complete;
   logic                               more_in_packet;
   logic                               last;
   logic                               clipped;

   always_comb begin
      if (cfg.bytes_per_pixel < tgarle_pkg::BPP_MIN) begin
         bpp = tgarle_pkg::BPP_MIN;
      end else if (cfg.bytes_per_pixel > tgarle_pkg::BPP_MAX) begin
         bpp = tgarle_pkg::BPP_MAX;
      end else begin
         bpp = cfg.bytes_per_pixel;
      end
      total = (cfg.pixel_total == '0) ? tgarle_pkg::TOTAL_RESET : cfg.pixel_total;

      header   = cfg.rle_mode && expect_header_ff;
      complete = ({1'b0, byte_index_ff} + 3'd1) >= bpp;

      for (int k = 0; k < tgarle_pkg::LANES; k++) begin
         pixel_buffer_in[k] = pixel_buffer_ff[k];
      end
      pixel_buffer_in[byte_index_ff] = in_byte;

      for (int k = 0; k < tgarle_pkg::LANES; k++) begin
         px[k] = (k < int'(bpp)) ? pixel_buffer_in[k] : '0;
      end
      if (bpp == tgarle_pkg::BPP_SWAP) begin
         px[0] = pixel_buffer_in[2];
         px[2] = pixel_buffer_in[0];
      end

      remaining = (total > pixels_done_ff) ? (total - pixels_done_ff)
                                           : tgarle_pkg::TOTAL_RESET;
      more_in_packet = 1'b0;
      if (!cfg.rle_mode) begin
         want = 8'd1;
      end else if (packet_is_run_ff) begin
         want = (packet_left_ff == '0) ? 8'd1 : packet_left_ff;
      end else begin
         want = 8'd1;
         more_in_packet = packet_left_ff > 8'd1;
      end
      want_wide = {{(tgarle_pkg::TOTAL_W-tgarle_pkg::COUNT_W){1'b0}}, want};
      last      = want_wide >= remaining;
      count     = last ? remaining[tgarle_pkg::COUNT_W-1:0] : want;
      clipped   = last && ((want_wide > remaining) || more_in_packet);

      expect_header_in = expect_header_ff;
      packet_is_run_in = packet_is_run_ff;
      packet_left_in   = packet_left_ff;
      byte_index_in    = byte_index_ff;
      pixels_done_in   = pixels_done_ff;

      if (header) begin
         expect_header_in = 1'b0;
         packet_is_run_in = in_byte[tgarle_pkg::RUN_BIT];
         packet_left_in   = (in_byte & tgarle_pkg::COUNT_MASK) + 8'd1;
         byte_index_in    = '0;
      end else if (!complete) begin
         byte_index_in = byte_index_ff + 2'd1;
      end else begin
         byte_index_in = '0;
         if (cfg.rle_mode) begin
            if (packet_is_run_ff || !more_in_packet) begin
               expect_header_in = 1'b1;
               packet_left_in   = '0;
            end else begin
               packet_left_in = packet_left_ff - 8'd1;
            end
         end
         if (last) begin
            pixels_done_in   = '0;
            expect_header_in = 1'b1;
            packet_is_run_in = 1'b0;
            packet_left_in   = '0;
         end else begin
            pixels_done_in = pixels_done_ff
                           + {{(tgarle_pkg::TOTAL_W-tgarle_pkg::COUNT_W){1'b0}}, count};
         end
      end

      res_valid        = accept && !header && complete;
      res.pix_byte0    = px[0];
      res.pix_byte1    = px[1];
      res.pix_byte2    = px[2];
      res.pix_byte3    = px[3];
      res.repeat_count = count;
      res.clipped      = clipped;
      res.last         = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_header_ff <= 1'b1;
         packet_is_run_ff <= 1'b0;
         packet_left_ff   <= '0;
         byte_index_ff    <= '0;
         pixels_done_ff   <= '0;
         for (int k = 0; k < tgarle_pkg::LANES; k++) begin
            pixel_buffer_ff[k] <= '0;
         end
      end else if (accept) begin
         expect_header_ff <= expect_header_in;
         packet_is_run_ff <= packet_is_run_in;
         packet_left_ff   <= packet_left_in;
         byte_index_ff    <= byte_index_in;
         pixels_done_ff   <= pixels_done_in;
         if (!header) begin
            for (int k = 0; k < tgarle_pkg::LANES; k++) begin
               pixel_buffer_ff[k] <= pixel_buffer_in[k];
            end
         end
      end
   end

endmodule

### rtl/core/tga_rle_pixel_decoder.sv
// Top level of the TGA pixel data decoder: configuration registers, the
// decode step and a two-entry result buffer. Depends on tgarle_pkg, tgarle_step.
//
//   port group   direction  moves
//   req_*        in         one byte of pixel data per item
//   rsp_*        out        one pixel with repeat count, clipped and last flags
//   csr_*        in         register writes, no read-back
//
// One byte is accepted per clock while req_stall is low; a pixel's result
// is registered in the output entry, or in the second entry while rsp_stall
// holds it. Header bytes and partial pixel bytes give no result. Reset is
// synchronous and restores register defaults and the start of an image.
// req_stall rises only while both result entries are full under rsp_stall.

module tga_rle_pixel_decoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [tgarle_pkg::BYTE_W-1:0]      req_in_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tgarle_pkg::BYTE_W-1:0]      rsp_pix_byte0,
   output logic [tgarle_pkg::BYTE_W-1:0]      rsp_pix_byte1,
   output logic [tgarle_pkg::BYTE_W-1:0]      rsp_pix_byte2,
   output logic [tgarle_pkg::BYTE_W-1:0]      rsp_pix_byte3,
   output logic [tgarle_pkg::COUNT_W-1:0]     rsp_repeat_count,
   output logic                               rsp_clipped,
   output logic                               rsp_last,
   input  logic                               csr_write_enable,
   input  logic [tgarle_pkg::CSR_ADDR_W-1:0]  csr_index,
   input  logic [tgarle_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   tgarle_pkg::cfg_type     cfg_ff;
   tgarle_pkg::result_type  step_res;
   tgarle_pkg::result_type  out_ff, out_in;
   tgarle_pkg::result_type  skid_ff, skid_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    skid_valid_ff, skid_valid_in;
   logic                    step_valid;
   logic                    accept;
   logic                    out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bytes_per_pixel <= tgarle_pkg::BPP_RESET;
         cfg_ff.rle_mode        <= 1'b1;
         cfg_ff.pixel_total     <= tgarle_pkg::TOTAL_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tgarle_pkg::CSR_BYTES_PER_PIXEL: begin
               cfg_ff.bytes_per_pixel <= csr_write_data[tgarle_pkg::BPP_W-1:0];
            end
            tgarle_pkg::CSR_RLE_MODE: begin
               cfg_ff.rle_mode <= csr_write_data[0];
            end
            tgarle_pkg::CSR_PIXEL_TOTAL: begin
               cfg_ff.pixel_total <= csr_write_data[tgarle_pkg::TOTAL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;

   tgarle_step u_step (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .cfg       (cfg_ff),
      .res_valid (step_valid),
      .res       (step_res)
   );

   always_comb begin
      out_free = !out_valid_ff || !rsp_stall;
      if (out_free) begin
         out_valid_in  = skid_valid_ff || step_valid;
         out_in        = skid_valid_ff ? skid_ff : step_res;
         skid_valid_in = skid_valid_ff && step_valid;
      end else begin
         out_valid_in  = 1'b1;
         out_in        = out_ff;
         skid_valid_in = skid_valid_ff || step_valid;
      end
      skid_in = (step_valid && (skid_valid_ff || !out_free)) ? step_res : skid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pix_byte0    = out_ff.pix_byte0;
   assign rsp_pix_byte1    = out_ff.pix_byte1;
   assign rsp_pix_byte2    = out_ff.pix_byte2;
   assign rsp_pix_byte3    = out_ff.pix_byte3;
   assign rsp_repeat_count = out_ff.repeat_count;
   assign rsp_clipped      = out_ff.clipped;
   assign rsp_last         = out_ff.last;

   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("result skid entry holds an item while the output is empty");

   a_clipped_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |-> rsp_last)
      else $error("clipped pixel result does not end the image");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_repeat_count != 8'd0 && rsp_repeat_count <= 8'd128))
      else $error("repeat count out of range");

   a_no_loss : assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_stall) |=> (skid_valid_ff && out_valid_ff))
      else $error("buffered item dropped while the output is stalled");

endmodule
